// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gtfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gtfs_pkg
// Types, character constants and match functions for the format sniffer.
// ----------------------------------------------------------------------------
package gtfs_pkg;

    typedef enum logic [2:0] {
        FT_UNKNOWN = 3'd0,
        FT_GFF     = 3'd1,
        FT_GTF     = 3'd2,
        FT_SAM     = 3'd3,
        FT_FASTQ   = 3'd4
    } file_type_t;

    typedef struct packed {
        logic gene;
        logic transcript;
        logic id;
        logic parent;
    } kw_bits_t;

    localparam int unsigned KW_CELLS       = 13;
    localparam int unsigned PREFIX_LEN     = 13;
    localparam int unsigned VERSION_IDX    = 14;
    localparam int unsigned SAM_TAG_IDX    = 2;
    localparam int unsigned KEYWORD_WINDOW = 200;
    localparam logic [2:0]  TAB_SAT        = 3'd7;
    localparam logic [2:0]  MIN_TABS_RST   = 3'd7;
    localparam logic [1:0]  ADDR_MIN_TABS  = 2'd0;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_TWO  = 8'h32;

    localparam logic [103:0] STR_PREFIX     = "##gff-version";
    localparam logic [103:0] STR_GENE       = "gene_id";
    localparam logic [103:0] STR_TRANSCRIPT = {"transcript", "_id"};
    localparam logic [103:0] STR_ID         = "ID=";
    localparam logic [103:0] STR_PARENT     = "Parent=";

    function automatic logic [7:0] char_at(logic [103:0] str, int unsigned len,
                                           int unsigned k);
        logic [7:0] c;
        c = 8'h00;
        if (k < len)
        begin
            c = str[8*(len-1-k) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] prefix_char(logic [3:0] idx);
        return char_at(STR_PREFIX, PREFIX_LEN, int'(idx));
    endfunction

    function automatic kw_bits_t kw_match(int unsigned k, logic [7:0] b);
        kw_bits_t m;
        m.gene       = (k < 7)  && (b == char_at(STR_GENE, 7, k));
        m.transcript = (k < 13) && (b == char_at(STR_TRANSCRIPT, 13, k));
        m.id         = (k < 3)  && (b == char_at(STR_ID, 3, k));
        m.parent     = (k < 7)  && (b == char_at(STR_PARENT, 7, k));
        return m;
    endfunction

    function automatic logic is_seq_base(logic [7:0] b);
        return (b == "A") || (b == "C") || (b == "G") || (b == "T") || (b == "N");
    endfunction

    function automatic logic is_sam_tag(logic [7:0] a, logic [7:0] b);
        return (a == "H" && b == "D") || (a == "S" && b == "Q") ||
               (a == "R" && b == "G") || (a == "P" && b == "G") ||
               (a == "C" && b == "O");
    endfunction

endpackage

// ----- design/gtfs_cell.sv -----
// ----------------------------------------------------------------------------
// gtfs_cell
// One position of the keyword matcher: holds the partial-match bits of all
// keywords up to this character and hands them to the next cell.
// ----------------------------------------------------------------------------
module gtfs_cell #(
    parameter int unsigned POS = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  logic               clear,
    input  logic [7:0]         data,
    input  gtfs_pkg::kw_bits_t prev,
    output gtfs_pkg::kw_bits_t hit,
    output gtfs_pkg::kw_bits_t match_bits
);
    import gtfs_pkg::*;

    kw_bits_t match_reg;
    kw_bits_t match_next;

    assign hit        = prev & kw_match(POS, data);
    assign match_bits = match_reg;

    always_comb
    begin
        match_next = match_reg;
        if (clear)
        begin
            match_next = '0;
        end
        else if (shift)
        begin
            match_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

// ----- design/genomic_text_format_sniffer.sv -----
// ----------------------------------------------------------------------------
// genomic_text_format_sniffer
// Classifies a text file as GFF, GTF, SAM, FASTQ or unknown from its header bytes.
// ----------------------------------------------------------------------------
// Input stream: one header byte per transfer on s_tdata, s_tlast on the final
// byte of a file. Output stream: one file type code per file on m_tdata.
// APB register 0 (address 0): min_tabs, reset 7.
// A byte is taken in every cycle with s_tvalid while s_tready is high.
// Keyword search runs through a row of 13 cells, one per keyword character,
// so the match for each byte settles in the cycle it is taken.
// On the last byte transfer the file type is registered into a free buffer entry.
// A two-entry result buffer holds results while m_tready is low; s_tready
// drops only when both entries are full.
// Bytes past MAX_BYTES are dropped, but s_tlast still ends the file.
// Reset clears all file state and sets min_tabs to 7; after each result the
// file state clears and the next byte starts a new file.
// ----------------------------------------------------------------------------
module genomic_text_format_sniffer #(
    parameter int unsigned MAX_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] file_type, [7:3] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gtfs_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

    logic [2:0]       min_tabs_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       version_reg, version_next;
    logic [7:0]       prev_reg, prev_next;
    logic             prefix_ok_reg, prefix_ok_next;
    logic [2:0]       tabs_reg, tabs_next;
    logic             line_done_reg, line_done_next;
    logic             nl_pending_reg, nl_pending_next;
    logic             fastq_reg, fastq_next;
    logic             sam_reg, sam_next;
    logic             gtf_seen_reg, gtf_seen_next;
    logic             gff_seen_reg, gff_seen_next;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    file_type_t       out_type_reg, out_type_next;
    file_type_t       skid_type_reg, skid_type_next;

    logic             in_xfer;
    logic             take;
    logic             file_end;
    logic             pop;
    logic             in_window;
    file_type_t       result;
    kw_bits_t         cell_prev [KW_CELLS];
    kw_bits_t         cell_hit  [KW_CELLS];
    kw_bits_t         cell_bits [KW_CELLS];

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_MIN_TABS) ? {29'b0, min_tabs_reg} : 32'b0;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_type_reg};

    assign in_xfer   = s_tvalid && s_tready;
    assign take      = in_xfer && (count_reg < CNT_W'(MAX_BYTES));
    assign file_end  = in_xfer && s_tlast;
    assign pop       = m_tvalid && m_tready;
    assign in_window = 32'(count_reg) < KEYWORD_WINDOW;

    genvar g;
    generate
        for (g = 0; g < KW_CELLS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_prev[g] = '1;
            end
            else
            begin : g_body
                assign cell_prev[g] = cell_bits[g-1];
            end
            gtfs_cell #(.POS(g)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (take),
                .clear      (file_end),
                .data       (s_tdata),
                .prev       (cell_prev[g]),
                .hit        (cell_hit[g]),
                .match_bits (cell_bits[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next      = count_reg;
        first_next      = first_reg;
        version_next    = version_reg;
        prev_next       = prev_reg;
        prefix_ok_next  = prefix_ok_reg;
        tabs_next       = tabs_reg;
        line_done_next  = line_done_reg;
        nl_pending_next = nl_pending_reg;
        fastq_next      = fastq_reg;
        sam_next        = sam_reg;
        gtf_seen_next   = gtf_seen_reg;
        gff_seen_next   = gff_seen_reg;
        if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            prev_next  = s_tdata;
            if (count_reg == '0)
            begin
                first_next = s_tdata;
            end
            if ((count_reg < CNT_W'(PREFIX_LEN)) &&
                (s_tdata != prefix_char(count_reg[3:0])))
            begin
                prefix_ok_next = 1'b0;
            end
            if (count_reg == CNT_W'(VERSION_IDX))
            begin
                version_next = s_tdata;
            end
            if (count_reg == CNT_W'(SAM_TAG_IDX))
            begin
                sam_next = is_sam_tag(prev_reg, s_tdata);
            end
            if (nl_pending_reg)
            begin
                fastq_next      = is_seq_base(s_tdata);
                nl_pending_next = 1'b0;
            end
            if (!line_done_reg)
            begin
                if (s_tdata == CH_LF)
                begin
                    line_done_next = 1'b1;
                    if (count_reg != '0)
                    begin
                        nl_pending_next = 1'b1;
                    end
                end
                else if ((s_tdata == CH_TAB) && (tabs_reg < TAB_SAT))
                begin
                    tabs_next = tabs_reg + 3'd1;
                end
            end
            if (in_window)
            begin
                if (cell_hit[6].gene || cell_hit[12].transcript)
                begin
                    gtf_seen_next = 1'b1;
                end
                if (cell_hit[2].id || cell_hit[6].parent)
                begin
                    gff_seen_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result = FT_UNKNOWN;
        if (32'(count_next) < 32'd4)
        begin
            result = FT_UNKNOWN;
        end
        else if ((32'(count_next) >= 32'd14) && prefix_ok_next)
        begin
            if ((32'(count_next) >= 32'd16) && (version_next == CH_TWO))
            begin
                result = FT_GTF;
            end
            else
            begin
                result = FT_GFF;
            end
        end
        else if ((first_next != CH_HASH) && (first_next != CH_AT) &&
                 (tabs_next >= min_tabs_reg) && (gtf_seen_next || gff_seen_next))
        begin
            result = gtf_seen_next ? FT_GTF : FT_GFF;
        end
        else if ((first_next == CH_AT) && sam_next)
        begin
            result = FT_SAM;
        end
        else if ((first_next == CH_AT) && fastq_next)
        begin
            result = FT_FASTQ;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        skid_valid_next = skid_valid_reg;
        skid_type_next  = skid_type_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_type_next   = skid_type_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = file_end;
                out_type_next  = result;
            end
        end
        else if (file_end)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_type_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_type_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tabs_reg <= MIN_TABS_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_MIN_TABS))
        begin
            min_tabs_reg <= pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            first_reg      <= '0;
            version_reg    <= '0;
            prev_reg       <= '0;
            prefix_ok_reg  <= 1'b1;
            tabs_reg       <= '0;
            line_done_reg  <= 1'b0;
            nl_pending_reg <= 1'b0;
            fastq_reg      <= 1'b0;
            sam_reg        <= 1'b0;
            gtf_seen_reg   <= 1'b0;
            gff_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (file_end)
            begin
                count_reg      <= '0;
                first_reg      <= '0;
                version_reg    <= '0;
                prev_reg       <= '0;
                prefix_ok_reg  <= 1'b1;
                tabs_reg       <= '0;
                line_done_reg  <= 1'b0;
                nl_pending_reg <= 1'b0;
                fastq_reg      <= 1'b0;
                sam_reg        <= 1'b0;
                gtf_seen_reg   <= 1'b0;
                gff_seen_reg   <= 1'b0;
            end
            else
            begin
                count_reg      <= count_next;
                first_reg      <= first_next;
                version_reg    <= version_next;
                prev_reg       <= prev_next;
                prefix_ok_reg  <= prefix_ok_next;
                tabs_reg       <= tabs_next;
                line_done_reg  <= line_done_next;
                nl_pending_reg <= nl_pending_next;
                fastq_reg      <= fastq_next;
                sam_reg        <= sam_next;
                gtf_seen_reg   <= gtf_seen_next;
                gff_seen_reg   <= gff_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_type_reg  <= out_type_next;
        skid_type_reg <= skid_type_next;
    end

endmodule

// ----- design/gtfs_chk.sv -----
// ----------------------------------------------------------------------------
// gtfs_chk
// Port-level checks for the format sniffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtfs_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "hold broken")
    `ASSERT_SAME(a_out_code, m_tvalid, (m_tdata <= 8'd4), "file type code out of range")
    `ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result pending")
    `ASSERT_SAME(a_result_src, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast), "no tlast")

endmodule

bind genomic_text_format_sniffer gtfs_chk u_gtfs_chk (.*);

// ----- tb/tb_genomic_text_format_sniffer.sv -----
// ----------------------------------------------------------------------------
// tb_genomic_text_format_sniffer
// Self-checking bench for the header-byte file type sniffer.
// ----------------------------------------------------------------------------
// Streams whole files into the byte port and predicts each file type with an
// in-bench model of the classifier. The model keeps its own copy of the
// min_tabs register. Every type that comes out is checked in order against
// that prediction. Directed files cover the gff-version header, the SAM tags,
// FASTQ, the tab-line keywords, the keyword window and the byte limit.
// Random files follow in several min_tabs phases, with random gaps on both
// sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_genomic_text_format_sniffer;
    import gtfs_pkg::*;

    localparam int unsigned SNIFF_MAX_BYTES = 256;
    localparam int unsigned RANDOM_BYTES    = 250;
    localparam int unsigned RANDOM_PHASES   = 5;
    localparam int unsigned HOLDOFF_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned REPORT_LIMIT    = 10;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_in
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] file_type, [7:3] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    genomic_text_format_sniffer #(
        .MAX_BYTES(SNIFF_MAX_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [2:0]  tabs_needed;
    int unsigned sn_count;
    logic [7:0]  sn_first;
    logic [7:0]  sn_version;
    logic        sn_prefix_ok;
    logic [2:0]  sn_tabs;
    logic        sn_line_done;
    logic        sn_nl_pending;
    logic        sn_fastq;
    logic        sn_sam;
    logic        sn_gtf_kw;
    logic        sn_gff_kw;
    logic [7:0]  sn_recent [12];

    file_type_t  pending_types[$];
    file_type_t  want_type;
    int unsigned mismatches;
    int unsigned files_sent;
    int unsigned bytes_sent;
    int unsigned types_checked;
    int unsigned cfg_writes;
    int unsigned idle_cycles;
    int unsigned sink_stall;
    bit          steady;
    bit          holdoff_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic string tr_keyword();
        string s;
        s = "transcript";
        return {s, "_id"};
    endfunction

    // ------------------------------------------------------------------
    // File type predictor
    // ------------------------------------------------------------------
    function automatic void sniff_clear();
        sn_count      = 0;
        sn_first      = 8'h00;
        sn_version    = 8'h00;
        sn_prefix_ok  = 1'b1;
        sn_tabs       = 3'd0;
        sn_line_done  = 1'b0;
        sn_nl_pending = 1'b0;
        sn_fastq      = 1'b0;
        sn_sam        = 1'b0;
        sn_gtf_kw     = 1'b0;
        sn_gff_kw     = 1'b0;
        foreach (sn_recent[i])
        begin
            sn_recent[i] = 8'h00;
        end
    endfunction

    function automatic logic kw_ends_here(string kw, logic [7:0] cur);
        int n;
        int k;
        n = kw.len();
        if (kw[n-1] != cur)
        begin
            return 1'b0;
        end
        for (k = 1; k < n; k++)
        begin
            if (kw[n-1-k] != sn_recent[k-1])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void sniff_take(logic [7:0] b);
        string       gff_head;
        logic [15:0] tag;
        int          k;
        gff_head = "##gff-version";
        if (sn_count == 0)
        begin
            sn_first = b;
        end
        if (sn_count < PREFIX_LEN && b != gff_head[sn_count])
        begin
            sn_prefix_ok = 1'b0;
        end
        if (sn_count == VERSION_IDX)
        begin
            sn_version = b;
        end
        if (sn_count == SAM_TAG_IDX)
        begin
            tag = {sn_recent[0], b};
            sn_sam = (tag == "HD") || (tag == "SQ") || (tag == "RG") ||
                     (tag == "PG") || (tag == "CO");
        end
        if (sn_nl_pending)
        begin
            sn_fastq = (b == "A") || (b == "C") || (b == "G") || (b == "T") ||
                       (b == "N");
            sn_nl_pending = 1'b0;
        end
        if (!sn_line_done)
        begin
            if (b == CH_LF)
            begin
                sn_line_done = 1'b1;
                if (sn_count >= 1)
                begin
                    sn_nl_pending = 1'b1;
                end
            end
            else if (b == CH_TAB && sn_tabs < TAB_SAT)
            begin
                sn_tabs = sn_tabs + 3'd1;
            end
        end
        if (sn_count < KEYWORD_WINDOW)
        begin
            if (kw_ends_here("gene_id", b) || kw_ends_here(tr_keyword(), b))
            begin
                sn_gtf_kw = 1'b1;
            end
            if (kw_ends_here("ID=", b) || kw_ends_here("Parent=", b))
            begin
                sn_gff_kw = 1'b1;
            end
        end
        for (k = $size(sn_recent) - 1; k > 0; k--)
        begin
            sn_recent[k] = sn_recent[k-1];
        end
        sn_recent[0] = b;
        sn_count++;
    endfunction

    function automatic file_type_t sniff_verdict();
        if (sn_count < 4)
        begin
            return FT_UNKNOWN;
        end
        if (sn_count >= PREFIX_LEN + 1 && sn_prefix_ok)
        begin
            return (sn_count >= VERSION_IDX + 2 && sn_version == CH_TWO) ? FT_GTF : FT_GFF;
        end
        if (sn_first != CH_HASH && sn_first != CH_AT && sn_tabs >= tabs_needed)
        begin
            if (sn_gtf_kw)
            begin
                return FT_GTF;
            end
            if (sn_gff_kw)
            begin
                return FT_GFF;
            end
        end
        if (sn_first == CH_AT && sn_sam)
        begin
            return FT_SAM;
        end
        if (sn_first == CH_AT && sn_fastq)
        begin
            return FT_FASTQ;
        end
        return FT_UNKNOWN;
    endfunction

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic void append_text(ref byte_q_t f, input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            f.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic void append_word(ref byte_q_t f);
        repeat ($urandom_range(1, 5))
        begin
            f.push_back(rand_letter());
        end
    endfunction

    function automatic byte_q_t make_file();
        byte_q_t     f;
        string       kws [4];
        string       tags [5];
        string       bases;
        int unsigned r;
        int unsigned n;
        int unsigned k;
        int unsigned at;
        int unsigned line;
        kws   = '{"gene_id", tr_keyword(), "ID=", "Parent="};
        tags  = '{"HD", "SQ", "RG", "PG", "CO"};
        bases = "ACGTN";
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            append_text(f, "##gff-version ");
            if ($urandom_range(0, 3) == 0)
            begin
                f[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom);
            end
            case ($urandom_range(0, 2))
                0:       f.push_back("2");
                1:       f.push_back("3");
                default: f.push_back(8'($urandom));
            endcase
            append_word(f);
            f.push_back(CH_LF);
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(4, f.size());
                while (f.size() > n)
                begin
                    void'(f.pop_back());
                end
            end
        end
        else if (r < 45)
        begin
            case ($urandom_range(0, 7))
                0:       f.push_back(CH_HASH);
                1:       f.push_back(8'($urandom));
                default: f.push_back(rand_letter());
            endcase
            for (line = 0; line < $urandom_range(1, 2); line++)
            begin
                repeat ($urandom_range(0, 8))
                begin
                    append_word(f);
                    f.push_back(CH_TAB);
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    k  = $urandom_range(0, 3);
                    at = f.size();
                    append_text(f, kws[k]);
                    if ($urandom_range(0, 5) == 0)
                    begin
                        f[at + $urandom_range(0, kws[k].len() - 1)] = 8'($urandom);
                    end
                end
                append_word(f);
                f.push_back(CH_LF);
            end
        end
        else if (r < 60)
        begin
            f.push_back(CH_AT);
            if ($urandom_range(0, 3) != 0)
            begin
                append_text(f, tags[$urandom_range(0, 4)]);
            end
            else
            begin
                f.push_back(8'($urandom_range(65, 90)));
                f.push_back(8'($urandom_range(65, 90)));
            end
            f.push_back(CH_TAB);
            append_word(f);
            f.push_back(CH_LF);
        end
        else if (r < 80)
        begin
            f.push_back(CH_AT);
            repeat ($urandom_range(0, 5))
            begin
                f.push_back(rand_letter());
            end
            f.push_back(CH_LF);
            if ($urandom_range(0, 7) != 0)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    f.push_back(bases[$urandom_range(0, 4)]);
                end
                else
                begin
                    f.push_back(8'($urandom));
                end
                repeat ($urandom_range(0, 8))
                begin
                    f.push_back(bases[$urandom_range(0, 4)]);
                end
                append_text(f, "\n+\n");
            end
        end
        else if (r < 96)
        begin
            repeat ($urandom_range(1, 24))
            begin
                f.push_back(8'($urandom));
            end
            case ($urandom_range(0, 3))
                0:       f[0] = CH_AT;
                1:       f[0] = CH_HASH;
                default: ;
            endcase
        end
        else
        begin
            // place a keyword so that it ends near the edge of the search window
            f.push_back(rand_letter());
            repeat ($urandom_range(0, 8))
            begin
                f.push_back(CH_TAB);
            end
            n  = $urandom_range(150, 320);
            k  = $urandom_range(0, 3);
            at = $urandom_range(KEYWORD_WINDOW - 20, KEYWORD_WINDOW + 15);
            while (f.size() < n)
            begin
                if (f.size() + kws[k].len() == at + 1)
                begin
                    append_text(f, kws[k]);
                end
                else
                begin
                    f.push_back(rand_letter());
                end
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (sn_count < SNIFF_MAX_BYTES)
        begin
            sniff_take(b);
        end
        if (lst)
        begin
            pending_types.push_back(sniff_verdict());
            sniff_clear();
            files_sent++;
        end
    endtask

    task automatic send_file(input byte_q_t f);
        int i;
        for (i = 0; i < f.size(); i++)
        begin
            send_byte(f[i], i == f.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        byte_q_t f;
        append_text(f, s);
        send_file(f);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_types.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic check_tabs_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MIN_TABS;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {29'd0, tabs_needed})
        begin
            note_mismatch("min_tabs readback", {29'd0, tabs_needed}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_min_tabs(input logic [2:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_TABS;
        pwdata  <= {29'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tabs_needed = val;
        cfg_writes++;
        check_tabs_readback();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_gff_header();
        byte_q_t f;
        send_text("ab\n");
        send_text("##gff-version 2\n");
        send_text("##gff-version 3\n");
        send_text("##gff-version 2");
        send_text("##gff-version");
        send_text("##gff-versiom 2\n");
        f = {8'h00, 8'hFF, 8'h00, 8'hFF};
        send_file(f);
    endtask

    task automatic test_sam_fastq();
        send_text("@HD\tVN:1.6\n");
        send_text("@SQ\tSN:c");
        send_text("@RG\tID:r");
        send_text("@PG\tID:p");
        send_text("@CO\tx");
        send_text("@XY\tx");
        send_text("@r\nACGT\n");
        send_text("@r\nN");
        send_text("@r\nx\n");
        send_text("@ab\n");
        send_text("@\nAA");
    endtask

    task automatic test_keywords();
        byte_q_t f;
        send_text("chr1\tsrc\tgene_id \"g\";\n");
        wait_drained();
        set_min_tabs(3'd2);
        send_text("chr1\tsrc\tgene_id \"g\";\n");
        send_text("c\tt\tID=7\n");
        send_text({"c\tt\t", tr_keyword(), " x"});
        send_text("c\tt\tParent=p");
        send_text("c\tgene_id x");
        send_text("#c\tt\tgene_id");
        append_text(f, "c\tt\tgene");
        f.push_back(8'h00);
        append_text(f, "id");
        send_file(f);
        wait_drained();
        set_min_tabs(3'd0);
        f = {};
        f.push_back("a");
        repeat (KEYWORD_WINDOW - 8) f.push_back("x");
        append_text(f, "gene_id");
        send_file(f);
        f = {};
        f.push_back("a");
        repeat (KEYWORD_WINDOW - 7) f.push_back("x");
        append_text(f, "gene_id");
        send_file(f);
        f = {};
        f.push_back("a");
        repeat (SNIFF_MAX_BYTES + 40) f.push_back("x");
        send_file(f);
        f = {};
        append_text(f, "@HD");
        repeat (SNIFF_MAX_BYTES + 40) f.push_back("x");
        send_file(f);
        wait_drained();
        set_min_tabs(TAB_SAT);
        send_text("c\t\t\t\t\t\t\t\t\tID=1");
    endtask

    task automatic test_holdoff();
        byte_q_t f;
        wait_drained();
        holdoff_req = 1'b1;
        steady      = 1'b1;
        append_text(f, "@SQ\t");
        repeat (16) send_file(f);
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        logic [2:0]  plan [RANDOM_PHASES];
        int unsigned phase;
        int unsigned goal;
        plan = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd1};
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase >= 2 && $urandom_range(0, 1) == 0)
            begin
                plan[phase] = 3'($urandom);
            end
            set_min_tabs(plan[phase]);
            goal = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
            while (bytes_sent < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    steady = !steady;
                end
                send_file(make_file());
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        m_tready   = 1'b0;
        sink_stall = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                sink_stall  = HOLDOFF_CYCLES;
            end
            else if (sink_stall == 0 && !steady)
            begin
                sink_stall = pick_gap();
            end
            if (sink_stall > 0)
            begin
                m_tready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_types.size() == 0)
            begin
                note_mismatch("result with no file pending", 32'd0, 32'(m_tdata));
            end
            else
            begin
                want_type = pending_types.pop_front();
                types_checked++;
                if (m_tdata !== {5'd0, want_type})
                begin
                    note_mismatch("file_type", 32'(want_type), 32'(m_tdata));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[genomic_text_format_sniffer] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = ADDR_MIN_TABS;
        pwdata        = 32'd0;
        mismatches    = 0;
        files_sent    = 0;
        bytes_sent    = 0;
        types_checked = 0;
        cfg_writes    = 0;
        idle_cycles   = 0;
        steady        = 1'b0;
        holdoff_req   = 1'b0;
        tabs_needed   = MIN_TABS_RST;
        sniff_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_tabs_readback();
        test_gff_header();
        test_sam_fastq();
        test_keywords();
        test_holdoff();
        test_random();
        wait_drained();
        repeat (8) @(posedge clk);
        $display("%0d files (%0d bytes) streamed, %0d types checked, %0d min_tabs writes",
                 files_sent, bytes_sent, types_checked, cfg_writes);
        $display("covered gff-version, tab-line keywords, SAM, FASTQ, noise, long files, stall");
        if (mismatches == 0 && pending_types.size() == 0)
        begin
            $display("[genomic_text_format_sniffer] OK");
        end
        else
        begin
            $display("[genomic_text_format_sniffer] ERROR");
        end
        $finish;
    end

endmodule
